### hw/rtl/hsv_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
package hsv_pkg;

   localparam int HUE_W      = 12;
   localparam int FRAC_W     = 10;
   localparam int LEVEL_W    = 8;
   localparam int REM_W      = 6;
   localparam int QUO60_W    = 7;
   localparam int TERM_W     = 16;
   localparam int PROD_W     = 26;
   localparam int SCALED_W   = 22;
   localparam int DIV_REM_W  = 15;
   localparam int PIPE_DEPTH = 7;

   localparam logic [FRAC_W-1:0]  FULL_SCALE   = 10'd1000;
   localparam logic [REM_W-1:0]   SPAN         = 6'd60;
   localparam logic [14:0]        RECIP60      = 15'd17477;
   localparam int                 RECIP60_SH   = 20;
   localparam logic [5:0]         RECIP6       = 6'd43;
   localparam int                 RECIP6_SH    = 8;
   localparam logic [2:0]         SEXT_COUNT   = 3'd6;
   localparam logic [TERM_W-1:0]  TOP_TERM     = 16'd60000;
   localparam logic [4:0]         LEVEL_MUL    = 5'd17;
   localparam int                 LEVEL_SH     = 8;
   localparam logic [13:0]        LEVEL_DIV    = 14'd15625;
   localparam logic [18:0]        RECIP_DIV    = 19'd274877;
   localparam int                 RECIP_DIV_SH = 32;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;

   typedef enum logic [2:0] {
      SEXT_RED_YEL = 3'd0,
      SEXT_YEL_GRN = 3'd1,
      SEXT_GRN_CYN = 3'd2,
      SEXT_CYN_BLU = 3'd3,
      SEXT_BLU_MAG = 3'd4,
      SEXT_MAG_RED = 3'd5
   } sextant_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      sextant_type       sext;
      logic [FRAC_W-1:0] sat;
      logic [FRAC_W-1:0] val;
   } split_type;

   typedef struct packed {
      logic [TERM_W-1:0] red;
      logic [TERM_W-1:0] green;
      logic [TERM_W-1:0] blue;
      logic [FRAC_W-1:0] val;
   } term_type;

endpackage

### hw/rtl/hsv_hue_split.sv
// Two pipeline stages: hue mod 360 split into sextant and remainder,
// saturation and brightness clamped. Depends on hsv_pkg.
module hsv_hue_split import hsv_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [HUE_W-1:0]  hue,
   input  logic [FRAC_W-1:0] sat,
   input  logic [FRAC_W-1:0] val,
   output split_type         split
);

   logic [HUE_W-1:0]   hue_ff;
   logic [QUO60_W-1:0] q60_ff, q60_in;
   logic [FRAC_W-1:0]  sat_ff, sat_in;
   logic [FRAC_W-1:0]  val_ff, val_in;
   split_type          split_ff, split_in;

   logic [26:0]        hue_prod;
   logic [12:0]        q_span;
   logic [12:0]        rem_full;
   logic [12:0]        q6_prod;
   logic [4:0]         q6;
   logic [QUO60_W-1:0] q6_span;
   logic [QUO60_W-1:0] sext_full;

   // stage 1: hue / 60 by reciprocal, exact for 12-bit hue
   always_comb begin
      hue_prod = 27'(hue) * 27'(RECIP60);
      q60_in   = QUO60_W'(hue_prod >> RECIP60_SH);
      sat_in   = (sat > FULL_SCALE) ? FULL_SCALE : sat;
      val_in   = (val > FULL_SCALE) ? FULL_SCALE : val;
   end

   // stage 2: remainder, and quotient mod 6 for the sextant
   always_comb begin
      q_span        = 13'(q60_ff) * 13'(SPAN);
      rem_full      = 13'(hue_ff) - q_span;
      q6_prod       = 13'(q60_ff) * 13'(RECIP6);
      q6            = 5'(q6_prod >> RECIP6_SH);
      q6_span       = QUO60_W'(q6) * QUO60_W'(SEXT_COUNT);
      sext_full     = q60_ff - q6_span;
      split_in.rem  = rem_full[REM_W-1:0];
      split_in.sext = sextant_type'(sext_full[2:0]);
      split_in.sat  = sat_ff;
      split_in.val  = val_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff   <= hue;
         q60_ff   <= q60_in;
         sat_ff   <= sat_in;
         val_ff   <= val_in;
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

### hw/rtl/hsv_term_route.sv
// One pipeline stage: forms the three channel terms over 60000 and
// routes them by sextant. Depends on hsv_pkg.
module hsv_term_route import hsv_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  split_type split,
   output term_type  term
);

   term_type          term_ff, term_in;
   logic [TERM_W-1:0] s_rem;
   logic [REM_W-1:0]  rem_c;
   logic [TERM_W-1:0] s_remc;
   logic [FRAC_W-1:0] sat_c;
   logic [TERM_W-1:0] lo_t, fall_t, rise_t;

   always_comb begin
      s_rem   = TERM_W'(split.sat) * TERM_W'(split.rem);
      rem_c   = SPAN - split.rem;
      s_remc  = TERM_W'(split.sat) * TERM_W'(rem_c);
      sat_c   = FULL_SCALE - split.sat;
      lo_t    = TERM_W'(sat_c) * TERM_W'(SPAN);
      fall_t  = TOP_TERM - s_rem;
      rise_t  = TOP_TERM - s_remc;
      term_in.val = split.val;
      case (split.sext)
         SEXT_RED_YEL: begin
            term_in.red = TOP_TERM; term_in.green = rise_t;   term_in.blue = lo_t;
         end
         SEXT_YEL_GRN: begin
            term_in.red = fall_t;   term_in.green = TOP_TERM; term_in.blue = lo_t;
         end
         SEXT_GRN_CYN: begin
            term_in.red = lo_t;     term_in.green = TOP_TERM; term_in.blue = rise_t;
         end
         SEXT_CYN_BLU: begin
            term_in.red = lo_t;     term_in.green = fall_t;   term_in.blue = TOP_TERM;
         end
         SEXT_BLU_MAG: begin
            term_in.red = rise_t;   term_in.green = lo_t;     term_in.blue = TOP_TERM;
         end
         default: begin
            term_in.red = TOP_TERM; term_in.green = lo_t;     term_in.blue = fall_t;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

### hw/rtl/hsv_level_scale.sv
// Four pipeline stages for one channel: floor(val * term * 255 / 6e7)
// by reciprocal estimate and one correction step. Depends on hsv_pkg.
module hsv_level_scale import hsv_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [TERM_W-1:0]  term,
   input  logic [FRAC_W-1:0]  val,
   output logic [LEVEL_W-1:0] level
);

   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SCALED_W-1:0]  scaled_ff, scaled_in;
   logic [SCALED_W-1:0]  scaled_d_ff;
   logic [LEVEL_W-1:0]   quo_ff, quo_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;

   logic [30:0]          mul17;
   logic [40:0]          est;
   logic [SCALED_W-1:0]  back;
   logic [SCALED_W-1:0]  rem_full;
   logic [DIV_REM_W-1:0] rem;
   logic                 bump;
   logic [LEVEL_W:0]     sum;

   always_comb begin
      prod_in   = PROD_W'(val) * PROD_W'(term);
      // val*term*17/4e6, with 4e6 = 256 * 15625
      mul17     = 31'(prod_ff) * 31'(LEVEL_MUL);
      scaled_in = SCALED_W'(mul17 >> LEVEL_SH);
      // underestimate of scaled / 15625, off by at most one
      est       = 41'(scaled_ff) * 41'(RECIP_DIV);
      quo_in    = LEVEL_W'(est >> RECIP_DIV_SH);
      back      = SCALED_W'(quo_ff) * SCALED_W'(LEVEL_DIV);
      rem_full  = scaled_d_ff - back;
      rem       = rem_full[DIV_REM_W-1:0];
      bump      = (rem >= DIV_REM_W'(LEVEL_DIV));
      sum       = (LEVEL_W+1)'(quo_ff) + (LEVEL_W+1)'(bump);
      level_in  = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         scaled_ff   <= scaled_in;
         scaled_d_ff <= scaled_ff;
         quo_ff      <= quo_in;
         level_ff    <= level_in;
      end
   end

   assign level = level_ff;

endmodule

### hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, top level. Uses hsv_pkg, hsv_hue_split,
// hsv_term_route and hsv_level_scale.
// Data and stage valid bits move in step through hue split, term route and level scale up to rsp_tvalid.
// Throughput: one transaction per clock; the seven stages advance together
// and hold as a whole while rsp_tvalid is high and rsp_tready low.
// Reset: synchronous, clears the stage valid bits only; data regs are not reset.
module hsv_to_rgb_converter import hsv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // hue_degrees[11:0], saturation[21:12], value_level[31:22]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // red_level[7:0], green_level[15:8], blue_level[23:16]
);

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic                  adv;
   split_type             split;
   term_type              term;
   logic [LEVEL_W-1:0]    red_level, green_level, blue_level;

   assign adv        = !valid_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];
   assign valid_in   = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   hsv_hue_split u_split (
      .clock (clock),
      .en    (adv),
      .hue   (req_tdata[HUE_W-1:0]),
      .sat   (req_tdata[HUE_W+FRAC_W-1:HUE_W]),
      .val   (req_tdata[HUE_W+2*FRAC_W-1:HUE_W+FRAC_W]),
      .split (split)
   );

   hsv_term_route u_route (
      .clock (clock),
      .en    (adv),
      .split (split),
      .term  (term)
   );

   hsv_level_scale u_red (
      .clock (clock),
      .en    (adv),
      .term  (term.red),
      .val   (term.val),
      .level (red_level)
   );

   hsv_level_scale u_green (
      .clock (clock),
      .en    (adv),
      .term  (term.green),
      .val   (term.val),
      .level (green_level)
   );

   hsv_level_scale u_blue (
      .clock (clock),
      .en    (adv),
      .term  (term.blue),
      .val   (term.val),
      .level (blue_level)
   );

   assign rsp_tdata = {blue_level, green_level, red_level};

`ifndef ASSERT_OFF
   a_stall_holds_valids: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during a stall");

   a_reset_empties_pipe: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted transaction did not enter the first stage");
`endif

endmodule
